### rtl/cvz_pkg.sv
// Shared constants, register codes and coefficient helper for the 3x3 convolution block.
`timescale 1ns / 1ps

package cvz_pkg;

    localparam int MAX_WIDTH_DEF  = 256;
    localparam int PIXEL_BITS_DEF = 16;

    localparam int WIDTH_BITS     = 9;
    localparam int KROW_BITS      = 24;
    localparam int COEF_BITS      = 8;
    localparam int APB_DATA_BITS  = 32;
    localparam int APB_ADDR_BITS  = 4;
    localparam int REG_IDX_BITS   = 2;

    // register indexes, taken from paddr[3:2]
    localparam logic [REG_IDX_BITS-1:0] REG_IMAGE_WIDTH = 2'd0;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_TOP  = 2'd1;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_MID  = 2'd2;
    localparam logic [REG_IDX_BITS-1:0] REG_KERNEL_BOT  = 2'd3;

    localparam logic [WIDTH_BITS-1:0] IMAGE_WIDTH_RST = 9'd256;
    localparam logic [KROW_BITS-1:0]  KERNEL_TOP_RST  = 24'd65791;
    localparam logic [KROW_BITS-1:0]  KERNEL_MID_RST  = 24'd131326;
    localparam logic [KROW_BITS-1:0]  KERNEL_BOT_RST  = 24'd65791;

    localparam int MIN_WIDTH = 3;

    typedef logic signed [COEF_BITS-1:0] coef_t;

    // pick coefficient k (0 = left) from a packed kernel row
    function automatic coef_t coef_pick(input logic [KROW_BITS-1:0] row, input int k);
        return coef_t'(row[COEF_BITS*k +: COEF_BITS]);
    endfunction

endpackage

### rtl/cvz_if.sv
// Stream interfaces for pixel items and result items.
`timescale 1ns / 1ps

interface cvz_pix_if #(
    parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic                         req_type;
    logic signed [PIXEL_BITS-1:0] pixel;

    modport source (output valid, output req_type, output pixel, input ready);
    modport sink   (input valid, input req_type, input pixel, output ready);
endinterface

interface cvz_res_if #(
    parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
);
    localparam int OUT_BITS = PIXEL_BITS + 11;

    logic                       valid;
    logic                       ready;
    logic signed [OUT_BITS-1:0] out_pixel;
    logic                       last_of_frame;

    modport source (output valid, output out_pixel, output last_of_frame, input ready);
    modport sink   (input valid, input out_pixel, input last_of_frame, output ready);
endinterface

### rtl/conv3x3_zero_border.sv
// Top level: streaming 3x3 convolution with zero border, line stores and APB registers.
`timescale 1ns / 1ps

// Streaming 3x3 convolution over a square frame of image_width x image_width signed
// samples in raster order. The block takes one item per clock, sustained, with no
// bubbles while the result output is not stalled: each line store is a RAM with one read
// and one write port, the read for the next raster column issued when an item is accepted,
// so the neighbourhood is ready when the item arrives.
// Each pixel item yields the output of the position image_width+1 raster steps
// earlier, so the first image_width+1 items of a frame give no result; after the last
// pixel, send image_width+1 flush items (req_type = 1) to drain the frame, the final
// one carrying last_of_frame. A flush in mid-frame counts as a pixel of value zero.
// Border outputs are zero. The nine products of an accepted item are registered, then
// the adder tree sums them into the output register.
// Registers (APB, 4-byte stride): 0 image_width (clamped to 3..MAX_WIDTH; writing it
// restarts the frame), 1..3 kernel rows top, middle, bottom, each three signed 8-bit
// coefficients with the left one in bits 7:0. Write registers only while idle.
// Line store contents after reset need no clearing: every row overwrites an entry
// before any interior output reads it.
module conv3x3_zero_border #(
    parameter int MAX_WIDTH  = cvz_pkg::MAX_WIDTH_DEF,
    parameter int PIXEL_BITS = cvz_pkg::PIXEL_BITS_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [cvz_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  logic [cvz_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [cvz_pkg::APB_DATA_BITS-1:0]  prdata,
    output logic                               pready,
    cvz_pix_if.sink                            pixels,
    cvz_res_if.source                          results
);
    import cvz_pkg::*;

    localparam int CW        = $clog2(MAX_WIDTH);      // column index
    localparam int PW        = $clog2(MAX_WIDTH + 2);  // row index and frame width
    localparam int PROD_BITS = PIXEL_BITS + COEF_BITS;
    localparam int SUM_BITS  = PROD_BITS + 4;
    localparam int OUT_BITS  = PIXEL_BITS + 11;
    localparam int TAPS      = 9;

    // ---------------------------------------------------------------- registers
    logic [WIDTH_BITS-1:0] image_width_reg;
    logic [KROW_BITS-1:0]  kernel_top_reg;
    logic [KROW_BITS-1:0]  kernel_mid_reg;
    logic [KROW_BITS-1:0]  kernel_bot_reg;

    logic [REG_IDX_BITS-1:0] reg_idx;
    logic                    cfg_write;
    logic                    width_write;

    assign pready      = 1'b1;
    assign reg_idx     = paddr[3:2];
    assign cfg_write   = psel && penable && pwrite && pready;
    assign width_write = cfg_write && (reg_idx == REG_IMAGE_WIDTH);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg <= IMAGE_WIDTH_RST;
            kernel_top_reg  <= KERNEL_TOP_RST;
            kernel_mid_reg  <= KERNEL_MID_RST;
            kernel_bot_reg  <= KERNEL_BOT_RST;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx)
                REG_IMAGE_WIDTH: image_width_reg <= pwdata[WIDTH_BITS-1:0];
                REG_KERNEL_TOP:  kernel_top_reg  <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_MID:  kernel_mid_reg  <= pwdata[KROW_BITS-1:0];
                REG_KERNEL_BOT:  kernel_bot_reg  <= pwdata[KROW_BITS-1:0];
                default:         ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_IMAGE_WIDTH: prdata = APB_DATA_BITS'(image_width_reg);
            REG_KERNEL_TOP:  prdata = APB_DATA_BITS'(kernel_top_reg);
            REG_KERNEL_MID:  prdata = APB_DATA_BITS'(kernel_mid_reg);
            REG_KERNEL_BOT:  prdata = APB_DATA_BITS'(kernel_bot_reg);
            default:         prdata = '0;
        endcase
    end

    // clamp the programmed width into the supported range
    logic [PW-1:0] eff_w;

    always_comb
    begin
        priority if (image_width_reg < WIDTH_BITS'(MIN_WIDTH))
            eff_w = PW'(MIN_WIDTH);
        else if (32'(image_width_reg) > MAX_WIDTH)
            eff_w = PW'(MAX_WIDTH);
        else
            eff_w = PW'(image_width_reg);
    end

    // ---------------------------------------------------------------- handshakes
    logic accept;
    logic a_valid_reg;
    logic out_valid_reg;
    logic out_move;

    assign out_move     = !out_valid_reg || results.ready;
    assign pixels.ready = !a_valid_reg || out_move;
    assign accept       = pixels.valid && pixels.ready;

    // ---------------------------------------------------------------- raster position
    logic [PW-1:0] row_reg;
    logic [CW-1:0] col_reg;
    logic [PW-1:0] row_next;
    logic [CW-1:0] col_next;
    logic [PW:0]   col_inc;
    logic          interior;
    logic          emit;
    logic          last;

    always_comb
    begin
        col_inc  = (PW + 1)'(col_reg) + 1'b1;
        interior = (row_reg >= PW'(2)) && ((PW + 1)'(row_reg) + 1'b1 <= (PW + 1)'(eff_w))
                   && (col_reg >= CW'(2));
        emit     = (row_reg >= PW'(2)) || ((row_reg == PW'(1)) && (col_reg != '0));
        last     = (PW + 1)'(row_reg) >= (PW + 1)'(eff_w) + 1'b1;

        priority if (last)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (col_inc >= (PW + 1)'(eff_w))
        begin
            row_next = row_reg + 1'b1;
            col_next = '0;
        end
        else
        begin
            row_next = row_reg;
            col_next = col_inc[CW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (width_write)
        begin
            // restart the frame; stores and window are kept
            row_reg <= '0;
            col_reg <= '0;
        end
        else if (accept)
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // ---------------------------------------------------------------- line stores
    // Read one column ahead: the registered read data always belongs to the
    // current column, so an item can be taken every cycle unless the output stalls.
    logic [PIXEL_BITS-1:0] upper_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] lower_mem [MAX_WIDTH];
    logic [PIXEL_BITS-1:0] upper_rd_reg;
    logic [PIXEL_BITS-1:0] lower_rd_reg;
    logic [CW-1:0]         rd_addr;

    logic signed [PIXEL_BITS-1:0] top;
    logic signed [PIXEL_BITS-1:0] mid;
    logic signed [PIXEL_BITS-1:0] bot;

    assign top = upper_rd_reg;
    assign mid = lower_rd_reg;
    assign bot = pixels.req_type ? '0 : pixels.pixel;

    always_comb
    begin
        priority if (width_write)
            rd_addr = '0;
        else if (accept)
            rd_addr = col_next;
        else
            rd_addr = col_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            upper_mem[col_reg] <= mid;
            lower_mem[col_reg] <= bot;
        end
        upper_rd_reg <= upper_mem[rd_addr];
        lower_rd_reg <= lower_mem[rd_addr];
    end

    // ---------------------------------------------------------------- window
    // entries 0..2 hold column c-2 (top, middle, bottom), 3..5 column c-1
    logic signed [PIXEL_BITS-1:0] window_reg [6];

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            window_reg[0] <= window_reg[3];
            window_reg[1] <= window_reg[4];
            window_reg[2] <= window_reg[5];
            window_reg[3] <= top;
            window_reg[4] <= mid;
            window_reg[5] <= bot;
        end
    end

    // ---------------------------------------------------------------- products
    logic signed [PIXEL_BITS-1:0] colv [3][3];
    logic signed [PROD_BITS-1:0]  prod_next [TAPS];
    logic signed [PROD_BITS-1:0]  prod_reg  [TAPS];
    logic                         a_last_reg;

    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            colv[0][k] = window_reg[k];
            colv[1][k] = window_reg[3 + k];
        end
        colv[2][0] = top;
        colv[2][1] = mid;
        colv[2][2] = bot;

        // kernel row selects the neighbourhood row, coefficient k the column
        for (int k = 0; k < 3; k++)
        begin
            prod_next[3*k + 0] = PROD_BITS'(coef_pick(kernel_top_reg, k))
                                 * PROD_BITS'(colv[k][0]);
            prod_next[3*k + 1] = PROD_BITS'(coef_pick(kernel_mid_reg, k))
                                 * PROD_BITS'(colv[k][1]);
            prod_next[3*k + 2] = PROD_BITS'(coef_pick(kernel_bot_reg, k))
                                 * PROD_BITS'(colv[k][2]);
            // border positions give zero
            if (!interior)
            begin
                prod_next[3*k + 0] = '0;
                prod_next[3*k + 1] = '0;
                prod_next[3*k + 2] = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            a_valid_reg <= 1'b0;
        else if (accept && emit)
            a_valid_reg <= 1'b1;
        else if (out_move)
            a_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (accept && emit)
        begin
            prod_reg   <= prod_next;
            a_last_reg <= last;
        end
    end

    // ---------------------------------------------------------------- sum and result
    logic signed [SUM_BITS-1:0] sum;
    logic signed [OUT_BITS-1:0] out_pixel_reg;
    logic                       out_last_reg;

    always_comb
    begin
        sum = '0;
        for (int i = 0; i < TAPS; i++)
            sum = sum + SUM_BITS'(prod_reg[i]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_move)
            out_valid_reg <= a_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (out_move && a_valid_reg)
        begin
            out_pixel_reg <= sum[OUT_BITS-1:0];
            out_last_reg  <= a_last_reg;
        end
    end

    assign results.valid         = out_valid_reg;
    assign results.out_pixel     = out_pixel_reg;
    assign results.last_of_frame = out_last_reg;

endmodule
